// ===== rtl/dsa_pkg.sv =====
// Package for the dense ID slot allocator.
// Holds sizes, codes, controller/datapath structs and a bit search helper.
// Depends on nothing.
package dsa_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int ID_BASE   = 100;

	localparam int ID_W      = 11;
	localparam int SLOT_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int HANDLE_W  = 32;
	localparam int ERR_W     = 2;

	localparam int FW_BITS   = 32;
	localparam int FW_IDX_W  = $clog2(FW_BITS);
	localparam int NUM_FW    = MAX_ITEMS / FW_BITS;
	localparam int FW_ADDR_W = SLOT_W - FW_IDX_W;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_DEL = 1'b1
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 2'd0,
		ERR_FULL     = 2'd1,
		ERR_NOT_LIVE = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic ex;
		logic push;
	} dsa_cmd_t;

	typedef struct packed {
		logic out_free;
	} dsa_sts_t;

	function automatic logic [FW_IDX_W-1:0] low_bit(input logic [FW_BITS-1:0] v);
		logic [FW_IDX_W-1:0] r;
		r = '0;
		for (int i = FW_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = FW_IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/dsa_in_if.sv =====
// Request channel of the dense ID slot allocator: valid/ready plus payload.
// Depends on dsa_pkg.
interface dsa_in_if import dsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [ID_W-1:0]     item_id;
	logic [HANDLE_W-1:0] item_handle;

	modport source (output valid, output operation, output item_id, output item_handle,
		input ready);
	modport sink (input valid, input operation, input item_id, input item_handle,
		output ready);
endinterface

// ===== rtl/dsa_out_if.sv =====
// Result channel of the dense ID slot allocator: valid/ready plus payload.
// Depends on dsa_pkg.
interface dsa_out_if import dsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ID_W-1:0]  assigned_id;
	logic [SLOT_W-1:0] slot_index;
	logic [CNT_W-1:0] item_count;
	logic [ERR_W-1:0] error_code;

	modport source (output valid, output assigned_id, output slot_index, output item_count,
		output error_code, input ready);
	modport sink (input valid, input assigned_id, input slot_index, input item_count,
		input error_code, output ready);
endinterface

// ===== rtl/dsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module dsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/dsa_ctrl.sv =====
// Controller of the dense ID slot allocator: sequences accept, read, update, respond.
// Depends on dsa_pkg.
module dsa_ctrl import dsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dsa_sts_t sts,
	output dsa_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.ex  = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.ex, cmd.push}))
		else $error("More than one datapath command in a cycle.");
	a_load_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.rd)
		else $error("Read did not follow load.");
	a_read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> cmd.ex)
		else $error("Update did not follow read.");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("Result pushed into a full output register.");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd || cmd.ex) |-> !req_ready)
		else $error("Request accepted while an item is in progress.");
`endif
endmodule

// ===== rtl/dsa_dp.sv =====
// Datapath of the dense ID slot allocator: maps, handle store, free bitmap, result.
// Depends on dsa_pkg and dsa_ram.
module dsa_dp import dsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dsa_cmd_t            cmd,
	output dsa_sts_t            sts,
	input  logic                req_operation,
	input  logic [ID_W-1:0]     req_item_id,
	input  logic [HANDLE_W-1:0] req_item_handle,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [ID_W-1:0]     rsp_assigned_id,
	output logic [SLOT_W-1:0]   rsp_slot_index,
	output logic [CNT_W-1:0]    rsp_item_count,
	output logic [ERR_W-1:0]    rsp_error_code
);
	op_t                 op_q;
	logic [ID_W-1:0]     id_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CNT_W-1:0]    fresh_q;
	logic [CNT_W-1:0]    count_q;
	logic [NUM_FW-1:0]   sum_q;
	logic [NUM_FW-1:0]   fwv_q;
	logic [FW_ADDR_W-1:0] fw_addr_q;

	logic [ID_W-1:0]     res_id_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [CNT_W-1:0]    res_cnt_q;
	err_t                res_err_q;
	logic                rsp_valid_q;

	logic [ID_W:0]       diff;
	logic                in_range;
	logic [SLOT_W-1:0]   off;
	logic                lt_fresh;
	logic [FW_ADDR_W-1:0] sum_low;
	logic [FW_ADDR_W-1:0] fw_raddr;
	logic [SLOT_W-1:0]   last;

	logic [FW_BITS-1:0]  fw_rdata;
	logic [FW_BITS-1:0]  fw_data;
	logic [SLOT_W-1:0]   i2s_rdata;
	logic [ID_W-1:0]     s2i_rdata;
	logic [HANDLE_W-1:0] h_rdata;

	logic                full;
	logic                found;
	logic [FW_IDX_W-1:0] b_add;
	logic [SLOT_W-1:0]   off_add;
	logic                live;
	logic                moving;
	logic                is_top;

	logic                i2s_we;
	logic [SLOT_W-1:0]   i2s_waddr;
	logic [SLOT_W-1:0]   i2s_wdata;
	logic                s2i_we;
	logic [SLOT_W-1:0]   s2i_waddr;
	logic [ID_W-1:0]     s2i_wdata;
	logic                h_we;
	logic [SLOT_W-1:0]   h_waddr;
	logic [HANDLE_W-1:0] h_wdata;
	logic                fw_we;
	logic [FW_BITS-1:0]  fw_wdata;

	always_comb begin
		diff     = {1'b0, id_q} - (ID_W + 1)'(ID_BASE);
		in_range = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(MAX_ITEMS));
		off      = diff[SLOT_W-1:0];
		lt_fresh = {1'b0, off} < fresh_q;
		sum_low  = '0;
		for (int i = NUM_FW - 1; i >= 0; i--) begin
			if (sum_q[i]) begin
				sum_low = FW_ADDR_W'(i);
			end
		end
		fw_raddr = (op_q == OP_ADD) ? sum_low : off[SLOT_W-1 -: FW_ADDR_W];
		last     = SLOT_W'(count_q - CNT_W'(1));
	end

	always_comb begin
		fw_data = fwv_q[fw_addr_q] ? fw_rdata : '0;
		full    = count_q >= CNT_W'(MAX_ITEMS);
		found   = |sum_q;
		b_add   = low_bit(fw_data);
		off_add = found ? {fw_addr_q, b_add} : fresh_q[SLOT_W-1:0];
		live    = in_range && lt_fresh && !fw_data[off[FW_IDX_W-1:0]];
		moving  = i2s_rdata != last;
		is_top  = {1'b0, off} == (fresh_q - CNT_W'(1));

		i2s_we    = 1'b0;
		i2s_waddr = off_add;
		i2s_wdata = count_q[SLOT_W-1:0];
		s2i_we    = 1'b0;
		s2i_waddr = count_q[SLOT_W-1:0];
		s2i_wdata = ID_W'(off_add);
		h_we      = 1'b0;
		h_waddr   = count_q[SLOT_W-1:0];
		h_wdata   = handle_q;
		fw_we     = 1'b0;
		fw_wdata  = fw_data & ~(FW_BITS'(1) << b_add);

		if (cmd.ex) begin
			if (op_q == OP_ADD) begin
				if (!full) begin
					i2s_we = 1'b1;
					s2i_we = 1'b1;
					h_we   = 1'b1;
					fw_we  = found;
				end
			end else if (live) begin
				i2s_waddr = s2i_rdata[SLOT_W-1:0];
				i2s_wdata = i2s_rdata;
				s2i_waddr = i2s_rdata;
				s2i_wdata = s2i_rdata;
				h_waddr   = i2s_rdata;
				h_wdata   = h_rdata;
				fw_wdata  = fw_data | (FW_BITS'(1) << off[FW_IDX_W-1:0]);
				i2s_we    = moving;
				s2i_we    = moving;
				h_we      = moving;
				fw_we     = !is_top;
			end
		end
	end

	dsa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ITEMS)) u_i2s (
		.clk(clk), .we(i2s_we), .waddr(i2s_waddr), .wdata(i2s_wdata),
		.re(cmd.rd), .raddr(off), .rdata(i2s_rdata)
	);

	dsa_ram #(.WIDTH(ID_W), .DEPTH(MAX_ITEMS)) u_s2i (
		.clk(clk), .we(s2i_we), .waddr(s2i_waddr), .wdata(s2i_wdata),
		.re(cmd.rd), .raddr(last), .rdata(s2i_rdata)
	);

	dsa_ram #(.WIDTH(HANDLE_W), .DEPTH(MAX_ITEMS)) u_handle (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(cmd.rd), .raddr(last), .rdata(h_rdata)
	);

	dsa_ram #(.WIDTH(FW_BITS), .DEPTH(NUM_FW)) u_free (
		.clk(clk), .we(fw_we), .waddr(fw_addr_q), .wdata(fw_wdata),
		.re(cmd.rd), .raddr(fw_raddr), .rdata(fw_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(req_operation);
			id_q     <= req_item_id;
			handle_q <= req_item_handle;
		end
		if (cmd.ex) begin
			res_cnt_q  <= count_q;
			res_slot_q <= '0;
			if (op_q == OP_ADD) begin
				res_id_q  <= '0;
				res_err_q <= ERR_FULL;
				if (!full) begin
					res_id_q   <= ID_W'(ID_BASE) + ID_W'(off_add);
					res_slot_q <= count_q[SLOT_W-1:0];
					res_cnt_q  <= count_q + CNT_W'(1);
					res_err_q  <= ERR_OK;
				end
			end else begin
				res_id_q  <= id_q;
				res_err_q <= ERR_NOT_LIVE;
				if (live) begin
					res_slot_q <= i2s_rdata;
					res_cnt_q  <= count_q - CNT_W'(1);
					res_err_q  <= ERR_OK;
				end
			end
		end
		if (cmd.push) begin
			rsp_assigned_id <= res_id_q;
			rsp_slot_index  <= res_slot_q;
			rsp_item_count  <= res_cnt_q;
			rsp_error_code  <= res_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q     <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			fwv_q       <= '0;
			fw_addr_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				fw_addr_q <= fw_raddr;
			end
			if (cmd.ex) begin
				if (op_q == OP_ADD) begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
						if (found) begin
							sum_q[fw_addr_q] <= |fw_wdata;
						end else begin
							fresh_q <= fresh_q + CNT_W'(1);
						end
					end
				end else if (live) begin
					count_q <= count_q - CNT_W'(1);
					if (is_top) begin
						fresh_q <= {1'b0, off};
					end else begin
						sum_q[fw_addr_q] <= 1'b1;
						fwv_q[fw_addr_q] <= 1'b1;
					end
				end
			end
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign sts.out_free = !rsp_valid_q || rsp_ready;
endmodule

// ===== rtl/dense_id_slot_allocator.sv =====
// Dense ID slot allocator. An add hands out the smallest freed ID, else the next fresh one, and
// appends the handle at the end of the dense store; a delete moves the last slot into the
// vacated one and returns the ID. Each request steps through accept, memory read, update and
// result register, as set by the read-modify-write of the map and free-bitmap memories; the
// result step waits for output register room. A new request is taken while the previous
// result waits there. The free bitmap uses per-row valid bits, so no clearing pass follows reset.
// Depends on dsa_pkg, dsa_in_if, dsa_out_if, dsa_ctrl and dsa_dp.
module dense_id_slot_allocator import dsa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	dsa_in_if.sink   req,
	dsa_out_if.source rsp
);
	dsa_cmd_t cmd;
	dsa_sts_t sts;

	dsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
		.sts(sts), .cmd(cmd)
	);

	dsa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_operation(req.operation), .req_item_id(req.item_id),
		.req_item_handle(req.item_handle),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_assigned_id(rsp.assigned_id), .rsp_slot_index(rsp.slot_index),
		.rsp_item_count(rsp.item_count), .rsp_error_code(rsp.error_code)
	);
endmodule

// ===== dv/tb_dense_id_slot_allocator.sv =====
// Self-checking testbench for the dense ID slot allocator: adds and deletes with random
// sender bursts and receiver stalls, checked against a behavioral model of the allocator.
// Depends on dsa_pkg, dsa_in_if, dsa_out_if and dense_id_slot_allocator.
module tb_dense_id_slot_allocator;
	import dsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ID_W-1:0]   assigned_id;
		logic [SLOT_W-1:0] slot_index;
		logic [CNT_W-1:0]  item_count;
		err_t              error_code;
	} alloc_result_t;

	class alloc_scoreboard;
		int unsigned id_to_slot[MAX_ITEMS];
		int unsigned slot_to_id[MAX_ITEMS];
		bit          free_mask[MAX_ITEMS];
		bit          live_mask[MAX_ITEMS];
		int unsigned next_fresh;
		int unsigned live_count;
		alloc_result_t pending[$];
		int unsigned errors;

		function void note_request(op_t op, logic [ID_W-1:0] id);
			alloc_result_t r;
			int unsigned off, slot, last, moved;
			bit found;
			r.assigned_id = '0;
			r.slot_index = '0;
			r.error_code = ERR_OK;
			found = 0;
			off = 0;
			if (op == OP_ADD) begin
				if (live_count >= MAX_ITEMS) begin
					r.error_code = ERR_FULL;
				end else begin
					for (int i = 0; i < MAX_ITEMS; i++) begin
						if (!found && free_mask[i]) begin
							off = i;
							found = 1;
						end
					end
					if (found) begin
						free_mask[off] = 0;
					end else begin
						off = next_fresh;
						next_fresh++;
					end
					slot = live_count;
					id_to_slot[off] = slot;
					slot_to_id[slot] = off;
					live_mask[off] = 1;
					live_count++;
					r.assigned_id = ID_W'(ID_BASE + off);
					r.slot_index = SLOT_W'(slot);
				end
			end else begin
				r.assigned_id = id;
				if (id < ID_BASE || id - ID_BASE >= MAX_ITEMS || !live_mask[id - ID_BASE]) begin
					r.error_code = ERR_NOT_LIVE;
				end else begin
					off = id - ID_BASE;
					slot = id_to_slot[off];
					last = live_count - 1;
					if (slot != last) begin
						moved = slot_to_id[last];
						slot_to_id[slot] = moved;
						id_to_slot[moved] = slot;
					end
					live_mask[off] = 0;
					live_count = last;
					if (next_fresh != 0 && off == next_fresh - 1) begin
						next_fresh = off;
					end else begin
						free_mask[off] = 1;
					end
					r.slot_index = SLOT_W'(slot);
				end
			end
			r.item_count = CNT_W'(live_count);
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(logic [ID_W-1:0] id, logic [SLOT_W-1:0] slot,
				logic [CNT_W-1:0] cnt, logic [ERR_W-1:0] err);
			alloc_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat: assigned_id %0d", id);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (id !== e.assigned_id) begin
				$error("assigned_id: expected %0d, actual %0d", e.assigned_id, id);
				errors++;
			end
			if (slot !== e.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", e.slot_index, slot);
				errors++;
			end
			if (cnt !== e.item_count) begin
				$error("item_count: expected %0d, actual %0d", e.item_count, cnt);
				errors++;
			end
			if (err !== e.error_code) begin
				$error("error_code: expected %0d, actual %0d", e.error_code, err);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	dsa_in_if req();
	dsa_out_if rsp();
	alloc_scoreboard sb = new();
	bit long_stall = 0;
	logic [ID_W-1:0] live_ids[$];

	dense_id_slot_allocator i_dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	always #5 clk = ~clk;

	initial begin
		req.valid = 0;
		req.operation = OP_ADD;
		req.item_id = '0;
		req.item_handle = '0;
		rsp.ready = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			sb.check_result(rsp.assigned_id, rsp.slot_index, rsp.item_count, rsp.error_code);
		end
	end

	initial begin
		int unsigned phase;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase = (phase + 1) % 600;
			if (long_stall) begin
				rsp.ready <= 0;
			end else if (phase < 150) begin
				rsp.ready <= 1;
			end else if (phase < 400) begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				rsp.ready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	task automatic send_request(op_t op, logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle);
		req.valid <= 1;
		req.operation <= op;
		req.item_id <= id;
		req.item_handle <= handle;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, id);
		if (op == OP_ADD && sb.pending[$].error_code == ERR_OK) begin
			live_ids.insert(live_ids.size(), sb.pending[$].assigned_id);
		end else if (op == OP_DEL && sb.pending[$].error_code == ERR_OK) begin
			foreach (live_ids[i]) begin
				if (live_ids[i] == id) begin
					live_ids.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic idle_sender(int unsigned cycles);
		req.valid <= 0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic random_request(int unsigned add_weight);
		logic [ID_W-1:0] id;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < add_weight) begin
			send_request(OP_ADD, ID_W'($urandom), $urandom);
		end else begin
			if (live_ids.size() != 0 && $urandom_range(0, 9) != 0) begin
				id = live_ids[$urandom_range(0, live_ids.size() - 1)];
			end else begin
				id = ID_W'($urandom);
			end
			send_request(OP_DEL, id, $urandom);
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned burst;
		@(posedge arst_n);
		@(posedge clk);
		send_request(OP_DEL, ID_W'(ID_BASE), 32'h0);
		send_request(OP_ADD, 11'h7ff, 32'hffff_ffff);
		send_request(OP_ADD, 11'h000, 32'h0000_0000);
		send_request(OP_ADD, 11'h555, 32'haaaa_5555);
		send_request(OP_ADD, 11'h2aa, 32'h5555_aaaa);
		send_request(OP_DEL, ID_W'(ID_BASE + 1), 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE + 1), 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE + 3), 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE - 1), 32'h0);
		send_request(OP_DEL, 11'h0, 32'h0);
		send_request(OP_DEL, 11'h7ff, 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE + MAX_ITEMS), 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE + MAX_ITEMS - 1), 32'h0);
		send_request(OP_ADD, 11'h0, 32'h1234_5678);
		send_request(OP_DEL, ID_W'(ID_BASE + 2), 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE), 32'h0);
		drain_results();

		fork
			begin
				long_stall = 1;
				repeat (300) @(posedge clk);
				long_stall = 0;
			end
			begin
				for (int i = 0; i < 40; i++) send_request(OP_ADD, ID_W'($urandom), $urandom);
				for (int i = 0; i < 20; i++) random_request(50);
			end
		join
		drain_results();
		repeat (4) @(posedge clk);

		while (sb.live_count < MAX_ITEMS) send_request(OP_ADD, ID_W'($urandom), $urandom);
		send_request(OP_ADD, ID_W'($urandom), $urandom);
		send_request(OP_DEL, ID_W'(ID_BASE + MAX_ITEMS - 1), 32'h0);
		send_request(OP_DEL, ID_W'(ID_BASE + MAX_ITEMS - 1), 32'h0);
		send_request(OP_ADD, ID_W'($urandom), $urandom);
		send_request(OP_ADD, ID_W'($urandom), $urandom);
		for (int i = 0; i < 100; i++) random_request(20);
		drain_results();

		sent = 0;
		while (sent < 300) begin
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst; b++) begin
				random_request(sent < 150 ? 60 : 40);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
		end
		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
